### rtl/bwc_pkg.sv
package bwc_pkg;

    // Output rows are padded to this many bytes
    localparam int ALIGN_BYTES = 4;
    localparam int ALIGN_W     = $clog2(ALIGN_BYTES);

    // Width of the byte and row arithmetic (holds any stride or window edge)
    localparam int XW = 16;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 13;

    // Pixel byte and register field widths
    localparam int BYTE_W  = 8;
    localparam int SIZE_W  = 13;
    localparam int POS_W   = 12;
    localparam int BPP_W   = 2;
    localparam logic [BPP_W-1:0] BPP_16BIT = 2'd2;
    localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h00;

    // Result sideband bits on m_tuser
    localparam int USER_W          = 4;
    localparam int USER_IS_PADDING = 0;
    localparam int USER_ROW_END    = 1;
    localparam int USER_WIN_ERROR  = 2;
    localparam int USER_RUN_LAST   = 3;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SRC_WIDTH   = 3'd0,
        REG_SRC_HEIGHT  = 3'd1,
        REG_BPP         = 3'd2,
        REG_CROP_X      = 3'd3,
        REG_CROP_Y      = 3'd4,
        REG_CROP_WIDTH  = 3'd5,
        REG_CROP_HEIGHT = 3'd6
    } cfg_reg_t;

    // One classified input byte, queued for the back end
    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic               err;
        logic               row_last;
        logic               frame_last;
        logic [ALIGN_W-1:0] pad;
    } bwc_entry_t;

endpackage

### rtl/bmp_window_crop_stream_core.sv
// Streaming crop of raw BMP pixel data. Source bytes enter on s_ one per
// transaction in stored row order, source row padding included; bytes inside
// the crop window leave on m_, each window row followed by zero bytes up to a
// 4-byte boundary, with row end, frame end and run end flagged. The block takes
// one input byte per cycle while the queue is not full; the output side emits
// one byte per cycle while m_tready is high, so a window row end that needs
// padding adds up to 3 bytes, absorbed by a 4-entry queue between the classifying
// front end and the expanding back end. Bytes are registered in the queue and
// at the output. If the window does not fit the source image (or a size is zero
// or above MAX_WIDTH / MAX_HEIGHT) every input byte yields one error transaction.
// Any write to a defined register restarts the frame; write registers only while
// the stream is idle. A bytes_per_pixel value other than 2 is taken as 3.
module bmp_window_crop_stream_core #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [bwc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bwc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bwc_pkg::BYTE_W-1:0]     s_tdata,   // pixel_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bwc_pkg::BYTE_W-1:0]     m_tdata,   // out_byte
    output logic                           m_tlast,   // frame_end
    output logic [bwc_pkg::USER_W-1:0]     m_tuser    // is_padding, row_end, window_error, run_last
);
    import bwc_pkg::*;

    bwc_entry_t push_entry, head;
    logic       q_push, q_pop, q_empty, q_full;

    bwc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (push_entry)
    );

    bwc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    bwc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/bwc_front.sv
module bwc_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [bwc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [bwc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bwc_pkg::BYTE_W-1:0]      s_tdata,
    input  logic                            q_full,
    output logic                            q_push,
    output bwc_pkg::bwc_entry_t             q_entry
);
    import bwc_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH * 3 + ALIGN_BYTES);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam logic [XW-1:0] MAX_W_L = XW'(MAX_WIDTH);
    localparam logic [XW-1:0] MAX_H_L = XW'(MAX_HEIGHT);

    function automatic logic [XW-1:0] times_bpp(input logic [XW-1:0] v, input logic bpp3);
        logic [XW-1:0] r;
        r = (v << 1) + (bpp3 ? v : '0);
        return r;
    endfunction

    // configuration registers
    logic [SIZE_W-1:0] src_width_reg, src_height_reg, crop_width_reg, crop_height_reg;
    logic [POS_W-1:0]  crop_x_reg, crop_y_reg;
    logic [BPP_W-1:0]  bpp_reg;

    // position counters
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic              bpp3;
    logic              err;
    logic [XW-1:0]     src_bytes, stride, first_byte, end_byte, crop_bytes;
    logic [XW-1:0]     win_right, win_bottom, col_x, row_x, col_inc, row_inc;
    logic [ALIGN_W-1:0] src_pad, row_pad;
    logic              in_window, row_last, frame_last, accept, cfg_hit;

    // derived window geometry
    always_comb begin
        bpp3       = (bpp_reg != BPP_16BIT);
        win_right  = XW'(crop_x_reg) + XW'(crop_width_reg);
        win_bottom = XW'(crop_y_reg) + XW'(crop_height_reg);
        err = (src_width_reg == '0) || (XW'(src_width_reg) > MAX_W_L) ||
              (src_height_reg == '0) || (XW'(src_height_reg) > MAX_H_L) ||
              (crop_width_reg == '0) || (crop_height_reg == '0) ||
              (win_right > XW'(src_width_reg)) || (win_bottom > XW'(src_height_reg));
        src_bytes  = times_bpp(XW'(src_width_reg), bpp3);
        src_pad    = ALIGN_W'(0) - src_bytes[ALIGN_W-1:0];
        stride     = src_bytes + XW'(src_pad);
        first_byte = times_bpp(XW'(crop_x_reg), bpp3);
        end_byte   = times_bpp(win_right, bpp3);
        crop_bytes = times_bpp(XW'(crop_width_reg), bpp3);
        row_pad    = ALIGN_W'(0) - crop_bytes[ALIGN_W-1:0];
    end

    // classify the incoming byte
    always_comb begin
        col_x      = XW'(col_reg);
        row_x      = XW'(row_reg);
        in_window  = (row_x >= XW'(crop_y_reg)) && (row_x < win_bottom) &&
                     (col_x >= first_byte) && (col_x < end_byte);
        row_last   = (col_x == end_byte - XW'(1));
        frame_last = row_last && (row_x == win_bottom - XW'(1));
        s_tready   = !q_full;
        accept     = s_tvalid && s_tready;
        q_push     = accept && (err || in_window);
        if (err) begin
            q_entry.data       = '0;
            q_entry.err        = 1'b1;
            q_entry.row_last   = 1'b0;
            q_entry.frame_last = 1'b0;
            q_entry.pad        = '0;
        end else begin
            q_entry.data       = s_tdata;
            q_entry.err        = 1'b0;
            q_entry.row_last   = row_last;
            q_entry.frame_last = frame_last;
            q_entry.pad        = row_last ? row_pad : '0;
        end
    end

    // column and row stepping; error holds the counters
    always_comb begin
        col_inc  = col_x + XW'(1);
        row_inc  = row_x + XW'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (accept && !err) begin
            if (col_inc >= stride) begin
                col_next = '0;
                row_next = (row_inc >= XW'(src_height_reg)) ? '0 : ROW_W'(row_inc);
            end else begin
                col_next = COL_W'(col_inc);
            end
        end
    end

    always_comb begin
        case (cfg_addr)
            REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_BPP, REG_CROP_X,
            REG_CROP_Y, REG_CROP_WIDTH, REG_CROP_HEIGHT: cfg_hit = cfg_wr_en;
            default: cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg   <= SIZE_W'(1);
            src_height_reg  <= SIZE_W'(1);
            bpp_reg         <= BPP_W'(3);
            crop_x_reg      <= '0;
            crop_y_reg      <= '0;
            crop_width_reg  <= SIZE_W'(1);
            crop_height_reg <= SIZE_W'(1);
            col_reg         <= '0;
            row_reg         <= '0;
        end else if (cfg_hit) begin
            case (cfg_addr)
                REG_SRC_WIDTH:   src_width_reg   <= cfg_wr_data;
                REG_SRC_HEIGHT:  src_height_reg  <= cfg_wr_data;
                REG_BPP:         bpp_reg         <= cfg_wr_data[BPP_W-1:0];
                REG_CROP_X:      crop_x_reg      <= cfg_wr_data[POS_W-1:0];
                REG_CROP_Y:      crop_y_reg      <= cfg_wr_data[POS_W-1:0];
                REG_CROP_WIDTH:  crop_width_reg  <= cfg_wr_data;
                REG_CROP_HEIGHT: crop_height_reg <= cfg_wr_data;
                default: ;
            endcase
            // any register write starts a new frame
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### rtl/bwc_queue.sv
module bwc_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  bwc_pkg::bwc_entry_t push_entry,
    input  logic                pop,
    output bwc_pkg::bwc_entry_t head,
    output logic                empty,
    output logic                full
);
    import bwc_pkg::*;

    bwc_entry_t          slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]    count_reg, count_next;
    logic                do_push, do_pop;

    always_comb begin
        empty   = (count_reg == '0);
        full    = (count_reg == (Q_PTR_W + 1)'(Q_DEPTH));
        do_push = push && !full;
        do_pop  = pop && !empty;
        head    = slot_reg[rd_ptr_reg];
        count_next = count_reg + (Q_PTR_W + 1)'(do_push) - (Q_PTR_W + 1)'(do_pop);
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

### rtl/bwc_back.sv
module bwc_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bwc_pkg::bwc_entry_t          head,
    input  logic                         q_empty,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [bwc_pkg::BYTE_W-1:0]   m_tdata,   // out_byte
    output logic                         m_tlast,   // frame_end
    output logic [bwc_pkg::USER_W-1:0]   m_tuser    // is_padding, row_end, window_error, run_last
);
    import bwc_pkg::*;

    logic [ALIGN_W-1:0] step_reg, step_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0]  m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;
    logic [USER_W-1:0]  m_tuser_reg, m_tuser_next;
    logic               out_free, fire, is_pad, last_step;

    // expand the head entry: data byte first, then its padding bytes
    always_comb begin
        out_free  = !m_tvalid_reg || m_tready;
        fire      = out_free && !q_empty;
        is_pad    = (step_reg != '0);
        last_step = (step_reg == head.pad);
        q_pop     = fire && last_step;

        step_next = step_reg;
        if (q_pop) begin
            step_next = '0;
        end else if (fire) begin
            step_next = step_reg + ALIGN_W'(1);
        end

        m_tvalid_next = fire ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tuser_next  = m_tuser_reg;
        if (fire) begin
            m_tdata_next                  = is_pad ? PAD_BYTE : head.data;
            m_tlast_next                  = last_step && head.frame_last;
            m_tuser_next[USER_IS_PADDING] = is_pad;
            m_tuser_next[USER_ROW_END]    = last_step && (is_pad || head.row_last);
            m_tuser_next[USER_WIN_ERROR]  = head.err;
            m_tuser_next[USER_RUN_LAST]   = last_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // output payload register
    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/bwc_checker.sv
module bwc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [bwc_pkg::BYTE_W-1:0]  m_tdata,
    input logic                        m_tlast,
    input logic [bwc_pkg::USER_W-1:0]  m_tuser
);
    import bwc_pkg::*;

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
        && $stable(m_tuser))
        else $error("result changed while stalled");

    // error transactions are bare single results
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_WIN_ERROR] |-> m_tuser[USER_RUN_LAST] && m_tdata == '0
        && !m_tuser[USER_IS_PADDING] && !m_tuser[USER_ROW_END] && !m_tlast)
        else $error("malformed window error result");

    // inserted padding is zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_IS_PADDING] |-> m_tdata == PAD_BYTE)
        else $error("padding byte not zero");

    // frame end is always a row end and closes the run
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[USER_ROW_END] && m_tuser[USER_RUN_LAST])
        else $error("frame end without row end");

endmodule

bind bmp_window_crop_stream_core bwc_checker u_bwc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
